// ===== hw/rtl/rbfp_pkg.sv =====
package rbfp_pkg;

    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DRY_FRICTION     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VISCOUS_FRICTION = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP         = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_SPEED       = 8'd3;

    localparam logic [19:0] DRY_RST      = 20'd0;
    localparam logic [16:0] VISC_RST     = 17'd0;
    localparam logic [16:0] MAX_STEP_RST = 17'd6554;
    localparam logic [16:0] STOP_RST     = 17'd328;

    // iterations of the bit-serial divide / square-root unit
    localparam int unsigned DU_ITER = 32;
    localparam int unsigned DU_CNT_W = 6;

    typedef enum logic {
        DU_DIV,
        DU_SQRT
    } t_du_mode;

    typedef struct packed {
        logic     start;
        t_du_mode mode;
    } t_du_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQSUM,
        ST_ROOT,
        ST_CHECK,
        ST_VISC,
        ST_FRIC,
        ST_DVM,
        ST_DVCHK,
        ST_NMUL,
        ST_NDIV,
        ST_NWAIT,
        ST_MMUL,
        ST_MADD,
        ST_DONE
    } t_state;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

// ===== hw/rtl/rbfp_divsqrt.sv =====
module rbfp_divsqrt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rbfp_pkg::t_du_req i_req,
    input  logic [63:0]      i_num,
    input  logic [31:0]      i_den,
    output logic             o_done,
    output logic [31:0]      o_res
);
    import rbfp_pkg::*;

    logic                r_busy;
    logic                r_done;
    t_du_mode            r_mode;
    logic [DU_CNT_W-1:0] r_cnt;
    logic [63:0]         r_num;
    logic [34:0]         r_rem;
    logic [31:0]         r_res;
    logic [31:0]         r_den;

    logic [34:0] t_val;
    logic [34:0] trial;
    logic        ge;

    // one quotient or root bit per cycle
    always_comb begin
        if (r_mode == DU_SQRT) begin
            t_val = {r_rem[32:0], r_num[63:62]};
            trial = {1'b0, r_res, 2'b01};
        end else begin
            t_val = {r_rem[33:0], r_num[63]};
            trial = {3'b000, r_den};
        end
        ge = (t_val >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DU_CNT_W'(DU_ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mode <= i_req.mode;
            r_den  <= i_den;
            r_res  <= '0;
            if (i_req.mode == DU_SQRT) begin
                r_rem <= '0;
                r_num <= i_num;
            end else begin
                r_rem <= {3'b000, i_num[63:32]};
                r_num <= {i_num[31:0], 32'd0};
            end
        end else if (r_busy) begin
            r_rem <= ge ? (t_val - trial) : t_val;
            r_res <= {r_res[30:0], ge};
            r_num <= (r_mode == DU_SQRT) ? {r_num[61:0], 2'b00} : {r_num[62:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== hw/rtl/rolling_ball_friction_predictor_unit.sv =====
// Rolling ball friction predictor. One item is taken at a time; o_in_stall
// stays high until its result is built. Speed roots and the velocity updates
// of each integration sub-step use the bit-serial divide / square-root unit
// (one root per speed, one divide per velocity component, none when the ball
// stops dead), and an item runs at most MAX_STEPS sub-steps. A finished result
// waits in the output register while the next item is taken. Configuration
// writes are always ready.
module rolling_ball_friction_predictor_unit #(
    parameter int unsigned MAX_STEPS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [31:0]                i_start_x,
    input  logic signed [31:0]                i_start_y,
    input  logic signed [31:0]                i_start_vx,
    input  logic signed [31:0]                i_start_vy,
    input  logic [22:0]                       i_horizon,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [31:0]                o_end_x,
    output logic signed [31:0]                o_end_y,
    output logic signed [31:0]                o_end_vx,
    output logic signed [31:0]                o_end_vy,
    output logic                              o_cut_short,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rbfp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);
    import rbfp_pkg::*;

    localparam int unsigned PW = 35 + $clog2(MAX_STEPS);
    localparam int unsigned SW = $clog2(MAX_STEPS + 1);

    t_state r_state, n_state;

    logic [19:0] r_dry;
    logic [16:0] r_visc;
    logic [16:0] r_max_step;
    logic [16:0] r_stop;

    logic signed [PW-1:0] r_px, r_py;
    logic signed [31:0]   r_vx, r_vy, r_nvx, r_nvy;
    logic [22:0]          r_left;
    logic [16:0]          r_dt;
    logic [SW-1:0]        r_steps;
    logic                 r_cut;
    logic                 r_axis;
    logic [63:0]          r_acc;
    logic [31:0]          r_speed;
    logic [33:0]          r_fric;
    logic [31:0]          r_dv;
    logic [67:0]          r_prod;

    logic                 r_out_valid;
    logic signed [31:0]   r_out_x, r_out_y, r_out_vx, r_out_vy;
    logic                 r_out_cut;

    logic [33:0] mul_a, mul_b;
    t_du_req     du_req;
    logic [63:0] du_num;
    logic        du_done;
    logic [31:0] du_res;

    logic signed [31:0] v_sel, nv_sel, nv_new;
    logic [31:0]        mag_v;
    logic signed [32:0] s_sum;
    logic [32:0]        mag_s;
    logic [49:0]        visc_rnd;
    logic [51:0]        dv_rnd;
    logic [35:0]        dv_full;
    logic [50:0]        mv_rnd;
    logic signed [PW-1:0] delta;
    logic [16:0]        dt_next;
    logic               out_take;

    rbfp_divsqrt u_du (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (du_req),
        .i_num   (du_num),
        .i_den   (r_speed),
        .o_done  (du_done),
        .o_res   (du_res)
    );

    function automatic logic signed [31:0] sat_pos(input logic signed [PW-1:0] p);
        logic [PW-32:0] top;
        top = p[PW-1:31];
        if ((top == '0) || (top == '1)) begin
            sat_pos = p[31:0];
        end else begin
            sat_pos = p[PW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    endfunction

    always_comb begin
        v_sel   = r_axis ? r_vy : r_vx;
        nv_sel  = r_axis ? r_nvy : r_nvx;
        mag_v   = mag32(v_sel);
        nv_new  = v_sel[31] ? (v_sel + $signed(du_res)) : (v_sel - $signed(du_res));
        s_sum   = {v_sel[31], v_sel} + {nv_sel[31], nv_sel};
        mag_s   = s_sum[32] ? (~s_sum + 33'd1) : s_sum;
        visc_rnd = r_prod[49:0] + 50'd32768;
        dv_rnd  = r_prod[51:0] + 52'd32768;
        dv_full = dv_rnd[51:16];
        mv_rnd  = r_prod[50:0] + 51'd65536;
        delta   = s_sum[32] ? -$signed({{(PW-34){1'b0}}, mv_rnd[50:17]})
                            : $signed({{(PW-34){1'b0}}, mv_rnd[50:17]});
        dt_next = ({6'd0, r_max_step} < r_left) ? r_max_step : r_left[16:0];
    end

    // shared multiplier, operands picked by state
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_SQ: begin
                mul_a = {2'b00, mag_v};
                mul_b = {2'b00, mag_v};
            end
            ST_VISC: begin
                mul_a = {17'd0, r_visc};
                mul_b = {2'b00, r_speed};
            end
            ST_DVM: begin
                mul_a = r_fric;
                mul_b = {17'd0, r_dt};
            end
            ST_NMUL: begin
                mul_a = {2'b00, r_dv};
                mul_b = {2'b00, mag_v};
            end
            ST_MMUL: begin
                mul_a = {1'b0, mag_s};
                mul_b = {17'd0, r_dt};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    assign out_take = r_out_valid && !i_out_stall;

    always_comb begin
        n_state     = r_state;
        du_req      = '{start: 1'b0, mode: DU_DIV};
        du_num      = r_prod[63:0] + {33'd0, r_speed[31:1]};
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_SQ;
            ST_SQ:    n_state = ST_SQSUM;
            ST_SQSUM: begin
                if (r_axis) begin
                    du_req  = '{start: 1'b1, mode: DU_SQRT};
                    du_num  = r_acc + r_prod[63:0];
                    n_state = ST_ROOT;
                end else begin
                    n_state = ST_SQ;
                end
            end
            ST_ROOT:  if (du_done) n_state = ST_CHECK;
            ST_CHECK: begin
                if ((r_left == '0) || (r_speed <= {15'd0, r_stop})
                        || (r_steps >= SW'(MAX_STEPS))) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_VISC;
                end
            end
            ST_VISC:  n_state = ST_FRIC;
            ST_FRIC:  n_state = ST_DVM;
            ST_DVM:   n_state = ST_DVCHK;
            ST_DVCHK: n_state = (dv_full > {4'd0, r_speed}) ? ST_MMUL : ST_NMUL;
            ST_NMUL:  n_state = ST_NDIV;
            ST_NDIV: begin
                du_req  = '{start: 1'b1, mode: DU_DIV};
                n_state = ST_NWAIT;
            end
            ST_NWAIT: if (du_done) n_state = r_axis ? ST_MMUL : ST_NMUL;
            ST_MMUL:  n_state = ST_MADD;
            ST_MADD:  n_state = r_axis ? ST_SQ : ST_MMUL;
            ST_DONE:  if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_px    <= {{(PW-32){i_start_x[31]}}, i_start_x};
                r_py    <= {{(PW-32){i_start_y[31]}}, i_start_y};
                r_vx    <= i_start_vx;
                r_vy    <= i_start_vy;
                r_left  <= i_horizon;
                r_steps <= '0;
                r_cut   <= 1'b0;
                r_axis  <= 1'b0;
            end
            ST_SQSUM: begin
                r_acc  <= r_prod[63:0];
                r_axis <= ~r_axis;
            end
            ST_ROOT:  if (du_done) r_speed <= du_res;
            ST_CHECK: begin
                if ((r_left != '0) && (r_speed > {15'd0, r_stop})) begin
                    if (r_steps >= SW'(MAX_STEPS)) begin
                        r_cut <= 1'b1;
                    end else begin
                        r_steps <= r_steps + 1'b1;
                        r_dt    <= dt_next;
                    end
                end
            end
            ST_FRIC:  r_fric <= {14'd0, r_dry} + visc_rnd[49:16];
            ST_DVCHK: begin
                r_dv   <= dv_full[31:0];
                r_axis <= 1'b0;
                // stop outright when the slowdown would reverse the ball
                if (dv_full > {4'd0, r_speed}) begin
                    r_nvx <= '0;
                    r_nvy <= '0;
                end
            end
            ST_NWAIT: begin
                if (du_done) begin
                    if (r_axis) r_nvy <= nv_new;
                    else        r_nvx <= nv_new;
                    r_axis <= ~r_axis;
                end
            end
            ST_MADD: begin
                if (r_axis) begin
                    r_py   <= r_py + delta;
                    r_vx   <= r_nvx;
                    r_vy   <= r_nvy;
                    r_left <= r_left - {6'd0, r_dt};
                end else begin
                    r_px <= r_px + delta;
                end
                r_axis <= ~r_axis;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && (!r_out_valid || !i_out_stall)) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && (!r_out_valid || !i_out_stall)) begin
            r_out_x   <= sat_pos(r_px);
            r_out_y   <= sat_pos(r_py);
            r_out_vx  <= r_vx;
            r_out_vy  <= r_vy;
            r_out_cut <= r_cut;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dry      <= DRY_RST;
            r_visc     <= VISC_RST;
            r_max_step <= MAX_STEP_RST;
            r_stop     <= STOP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DRY_FRICTION:     r_dry      <= i_cfg_data[19:0];
                CFG_VISCOUS_FRICTION: r_visc     <= i_cfg_data[16:0];
                CFG_MAX_STEP:         r_max_step <= i_cfg_data[16:0];
                CFG_STOP_SPEED:       r_stop     <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_end_x     = r_out_x;
    assign o_end_y     = r_out_y;
    assign o_end_vx    = r_out_vx;
    assign o_end_vy    = r_out_vy;
    assign o_cut_short = r_out_cut;

endmodule

// ===== dv/rolling_ball_friction_predictor_unit_tb.sv =====
`timescale 1ns / 100ps

module rolling_ball_friction_predictor_unit_tb;
    import rbfp_pkg::*;

    localparam int unsigned STEP_CAP = 1024;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               cut;
    } t_ball_end;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic signed [31:0]     i_start_x = '0;
    logic signed [31:0]     i_start_y = '0;
    logic signed [31:0]     i_start_vx = '0;
    logic signed [31:0]     i_start_vy = '0;
    logic [22:0]            i_horizon = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic signed [31:0]     o_end_x;
    logic signed [31:0]     o_end_y;
    logic signed [31:0]     o_end_vx;
    logic signed [31:0]     o_end_vy;
    logic                   o_cut_short;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [31:0]            i_cfg_data = '0;

    // predictor copy of the registers, kept at 64 bits for the arithmetic
    logic [63:0] dry_q = 64'(DRY_RST);
    logic [63:0] visc_q = 64'(VISC_RST);
    logic [63:0] step_q = 64'(MAX_STEP_RST);
    logic [63:0] stop_q = 64'(STOP_RST);

    t_ball_end expected_ends[$];
    int        n_errors = 0;
    bit        quiet = 1'b0;

    rolling_ball_friction_predictor_unit #(.MAX_STEPS(STEP_CAP)) dut (.*);

    always #1 i_clk = ~i_clk;

    initial begin
        #40_000_000;
        $display("rolling_ball_friction_predictor_unit_tb: FAIL");
        $finish;
    end

    function automatic logic [63:0] mag(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] a);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > a) b >>= 2;
        while (b != 0) begin
            if (a >= res + b) begin
                a -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] speed_of(input longint vx, input longint vy);
        return root64(mag(vx) * mag(vx) + mag(vy) * mag(vy));
    endfunction

    function automatic longint slowed(input longint v, input logic [63:0] dv,
                                      input logic [63:0] spd);
        logic [63:0] q;
        q = (dv * mag(v) + spd / 2) / spd;
        return v < 0 ? v + $signed(q) : v - $signed(q);
    endfunction

    function automatic longint travel(input longint vo, input longint vn,
                                      input logic [63:0] dt);
        longint      s;
        logic [63:0] r;
        s = vo + vn;
        r = (mag(s) * dt + 64'h10000) >> 17;
        return s < 0 ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [31:0] sat32(input longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic t_ball_end roll_ball(input logic signed [31:0] x, y, vx0, vy0,
                                            input logic [22:0] h);
        t_ball_end   e;
        longint      px, py, vx, vy, nvx, nvy;
        logic [63:0] left, dt, visc, dv, spd;
        int          steps;
        px = x; py = y; vx = vx0; vy = vy0;
        left = 64'(h);
        steps = 0;
        e.cut = 1'b0;
        spd = speed_of(vx, vy);
        while (left > 0 && spd > stop_q) begin
            if (steps >= STEP_CAP) begin
                e.cut = 1'b1;
                break;
            end
            steps++;
            dt = left < step_q ? left : step_q;
            visc = (visc_q * spd + 64'h8000) >> 16;
            dv = ((dry_q + visc) * dt + 64'h8000) >> 16;
            if (dv > spd) begin
                nvx = 0;
                nvy = 0;
            end else begin
                nvx = slowed(vx, dv, spd);
                nvy = slowed(vy, dv, spd);
            end
            px += travel(vx, nvx, dt);
            py += travel(vy, nvy, dt);
            vx = nvx;
            vy = nvy;
            left -= dt;
            spd = speed_of(vx, vy);
        end
        e.x = sat32(px);
        e.y = sat32(py);
        e.vx = vx[31:0];
        e.vy = vy[31:0];
        return e;
    endfunction

    // receiver side: random back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(0, 99) < 12);
    end

    always @(posedge i_clk) begin
        t_ball_end e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_ends.size() == 0) begin
                $error("result with no item outstanding");
                n_errors++;
            end else begin
                e = expected_ends.pop_front();
                if (o_end_x !== e.x) begin
                    $error("end_x: expected %0d, got %0d", e.x, o_end_x);
                    n_errors++;
                end
                if (o_end_y !== e.y) begin
                    $error("end_y: expected %0d, got %0d", e.y, o_end_y);
                    n_errors++;
                end
                if (o_end_vx !== e.vx) begin
                    $error("end_vx: expected %0d, got %0d", e.vx, o_end_vx);
                    n_errors++;
                end
                if (o_end_vy !== e.vy) begin
                    $error("end_vy: expected %0d, got %0d", e.vy, o_end_vy);
                    n_errors++;
                end
                if (o_cut_short !== e.cut) begin
                    $error("cut_short: expected %0b, got %0b", e.cut, o_cut_short);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_ball(input logic signed [31:0] x, y, vx, vy,
                             input logic [22:0] h);
        while (!quiet && $urandom_range(0, 99) < 12) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_start_x <= x;
        i_start_y <= y;
        i_start_vx <= vx;
        i_start_vy <= vy;
        i_horizon <= h;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_ends.push_back(roll_ball(x, y, vx, vy, h));
        @(negedge i_clk);
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_ends.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_DRY_FRICTION:     dry_q = 64'(data[19:0]);
            CFG_VISCOUS_FRICTION: visc_q = 64'(data[16:0]);
            CFG_MAX_STEP:         step_q = 64'(data[16:0]);
            CFG_STOP_SPEED:       stop_q = 64'(data[16:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_friction(input logic [31:0] dry, visc, stp, stop);
        write_reg(CFG_DRY_FRICTION, dry);
        write_reg(CFG_VISCOUS_FRICTION, visc);
        write_reg(CFG_MAX_STEP, stp);
        write_reg(CFG_STOP_SPEED, stop);
    endtask

    task automatic test_defaults;
        send_ball(32'sd100, -32'sd100, 32'sd65536, -32'sd32768, 23'd65536);
        send_ball(32'sd5, 32'sd6, 32'sd100000, 32'sd0, 23'd0);      // zero horizon
        send_ball(32'sd5, 32'sd6, 32'sd200, -32'sd200, 23'd65536);  // already slow
        send_ball(32'sd0, 32'sd0, 32'sd329, 32'sd0, 23'd1);
        drain();
    endtask

    task automatic test_extremes;
        set_friction(32'd0, 32'd0, 32'd65536, 32'd0);
        // coasting off the edge saturates the position
        send_ball(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                  23'h40_0000);
        send_ball(-32'sd1, 32'sd1, 32'sh8000_0000, 32'sh8000_0000, 23'h3f_ffff);
        drain();
        set_friction(32'd655360, 32'd65536, 32'd65536, 32'd65536);
        // deceleration overshoots the speed: ball stops dead
        send_ball(32'sd0, 32'sd0, 32'sd70000, -32'sd3, 23'h40_0000);
        send_ball(32'sh7fff_ffff, -32'sd1, -32'sd1, 32'sh7fff_ffff, 23'h3f_ffff);
        drain();
        // step cap reached on a slow-decaying ball
        set_friction(32'd1, 32'd0, 32'd7, 32'd0);
        send_ball(32'sd0, 32'sd0, 32'sd65536, 32'sd65536, 23'h40_0000);
        drain();
        set_friction(32'd0, 32'd0, 32'd0, 32'd328);  // zero sub-step
        send_ball(32'sd10, 32'sd10, 32'sd65536, 32'sd0, 23'd100);
        drain();
        write_reg(8'd7, 32'hffff_ffff);               // unmapped index
        set_friction(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_ball(32'sd1, 32'sd2, 32'sh4000_0000, -32'sh4000_0000, 23'd70000);
        drain();
    endtask

    task automatic random_balls(input int count);
        logic [63:0] hmax;
        logic [22:0] h;
        logic signed [31:0] vx, vy;
        for (int i = 0; i < count; i++) begin
            hmax = step_q * 8;
            if (hmax > 64'h40_0000) hmax = 64'h40_0000;
            h = 23'($urandom_range(0, 32'(hmax)));
            if (step_q >= 32768 && $urandom_range(0, 19) == 0)
                h = 23'($urandom_range(0, 32'h40_0000));
            case ($urandom_range(0, 3))
                0: begin vx = $urandom; vy = $urandom; end
                1: begin vx = $signed($urandom_range(0, 2000)) - 1000;
                         vy = $signed($urandom_range(0, 2000)) - 1000; end
                default: begin vx = $signed($urandom_range(0, 800000)) - 400000;
                               vy = $signed($urandom_range(0, 800000)) - 400000; end
            endcase
            send_ball($urandom, $urandom, vx, vy, h);
        end
        drain();
    endtask

    task automatic test_random;
        random_balls(100);
        set_friction(32'd655360, 32'd65536, 32'd65536, 32'd65536);
        random_balls(100);
        quiet = 1'b1;
        set_friction(32'd1000, 32'd3000, 32'd7, 32'd0);
        random_balls(100);
        quiet = 1'b0;
        set_friction(32'd20000, 32'd500, 32'd40000, 32'd10);
        random_balls(100);
        set_friction($urandom_range(0, 655360), $urandom_range(0, 65536),
                     $urandom_range(7, 65536), $urandom_range(0, 65536));
        random_balls(100);
        set_friction($urandom_range(0, 20000), $urandom_range(0, 65536),
                     $urandom_range(1000, 65536), $urandom_range(0, 2000));
        random_balls(100);
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_defaults();
        test_extremes();
        test_random();
        if (n_errors == 0) begin
            $display("rolling_ball_friction_predictor_unit_tb: PASS");
        end else begin
            $display("rolling_ball_friction_predictor_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
